// ===== rtl/tnw_pkg.sv =====
// package for the text whitespace normalizer
// character constants, register map and the controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tnw_pkg;

  localparam int unsigned CHAR_W = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [CHAR_W-1:0] CHR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHR_CR      = 8'h0d;
  localparam int unsigned       HIGH_BIT    = 7;

  // register map
  localparam int unsigned APB_ADDR_W          = 3;
  localparam int unsigned APB_DATA_W          = 32;
  localparam logic        REG_SENTENCE_MODE   = 1'b0;
  localparam logic        SENTENCE_MODE_RESET = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic flush_load;  // move one buffered whitespace byte to the output
    logic char_load;   // move the held text byte to the output
  } tnw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a beat this cycle
    logic need_flush;  // current input byte must first drain the buffer
    logic flush_done;  // the byte being drained is the last buffered one
  } tnw_status_t;

endpackage

`default_nettype wire

// ===== rtl/tnw_ctrl.sv =====
// controller for the text whitespace normalizer
// sequences input acceptance, buffer drain and held byte emission
// depends on tnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tnw_ctrl
  import tnw_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  tnw_status_t status,
  output tnw_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_CHAR  = 3'b100
  } state_t;

  state_t state, state_next;

  assign s_tready       = (state == S_IDLE) && status.out_free;
  assign cmd.accept     = s_tvalid && s_tready;
  assign cmd.flush_load = (state == S_FLUSH) && status.out_free;
  assign cmd.char_load  = (state == S_CHAR) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && status.need_flush) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (cmd.flush_load && status.flush_done) state_next = S_CHAR;
      end
      S_CHAR: begin
        if (cmd.char_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tnw_datapath.sv =====
// datapath for the text whitespace normalizer
// byte mapping, run collapse, pending whitespace buffer and output register
// depends on tnw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tnw_datapath
  import tnw_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire                cfg_mode,
  output logic               sentence_mode,
  input  wire  [CHAR_W-1:0]  s_tdata,
  input  wire                s_tlast,
  input  tnw_cmd_t           cmd,
  output tnw_status_t        status,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [CHAR_W-1:0]  m_tdata,   // char_out
  output logic [1:0]         m_tuser,   // [0] char_valid, [1] overflow
  output logic               m_tlast
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // string state
  logic          seen;
  logic          prev_space;
  logic [CW-1:0] count;
  logic          ovf;

  // held text byte while the buffer drains
  logic [CHAR_W-1:0] hold_char;
  logic              hold_last;
  logic [AW-1:0]     idx;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_cv;
  logic              out_last;
  logic              out_ovf;

  logic [CHAR_W-1:0] mapped;
  logic              is_ws;
  logic              is_sp;
  logic              collapse;
  logic              emit_char;
  logic              emit_mark;
  logic              buf_wr;
  logic              set_ovf;
  logic              do_flush;
  logic              upd_prev;
  logic              clear_str;

  always_comb begin
    mapped = s_tdata;
    if (s_tdata >= CHR_UPPER_A && s_tdata <= CHR_UPPER_Z) mapped = s_tdata + CASE_OFFSET;
    if (s_tdata[HIGH_BIT]) mapped = CHR_SPACE;
  end

  assign is_sp    = (mapped == CHR_SPACE);
  assign is_ws    = is_sp || (mapped >= CHR_TAB && mapped <= CHR_CR);
  assign collapse = is_sp && prev_space;

  always_comb begin
    emit_char = 1'b0;
    emit_mark = 1'b0;
    buf_wr    = 1'b0;
    set_ovf   = 1'b0;
    do_flush  = 1'b0;
    if (!sentence_mode) begin
      if (!collapse) emit_char = 1'b1;
      else if (s_tlast) emit_mark = 1'b1;
    end else if (!is_ws) begin
      if (count == '0) emit_char = 1'b1;
      else do_flush = 1'b1;
    end else begin
      if (seen && !collapse) begin
        if (count < CW'(DEPTH)) buf_wr = 1'b1;
        else set_ovf = 1'b1;
      end
      if (s_tlast) emit_mark = 1'b1;
    end
  end

  assign upd_prev  = (!sentence_mode && !collapse) || (sentence_mode && !is_ws) || buf_wr;
  assign clear_str = cfg_we || (cmd.accept && s_tlast && !do_flush)
                   || (cmd.char_load && hold_last);

  assign status.out_free   = !out_valid || m_tready;
  assign status.need_flush = do_flush;
  assign status.flush_done = ((CW'(idx) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      sentence_mode <= SENTENCE_MODE_RESET;
    end else if (cfg_we) begin
      sentence_mode <= cfg_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_str) begin
      seen       <= 1'b0;
      prev_space <= 1'b0;
      count      <= '0;
      ovf        <= 1'b0;
    end else if (cmd.accept) begin
      if (upd_prev) prev_space <= is_sp;
      if (sentence_mode && !is_ws) seen <= 1'b1;
      if (buf_wr) count <= count + CW'(1);
      if (set_ovf) ovf <= 1'b1;
    end else if (cmd.char_load) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_char <= mapped;
      hold_last <= s_tlast;
      idx       <= '0;
    end else if (cmd.flush_load) begin
      idx <= idx + AW'(1);
    end
  end

  // first read issued with the accept, then one read ahead per drained byte
  assign rd_en   = (cmd.accept && do_flush) || (cmd.flush_load && !status.flush_done);
  assign rd_addr = cmd.accept ? '0 : idx + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept && buf_wr) mem[count[AW-1:0]] <= mapped;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && (emit_char || emit_mark)) || cmd.flush_load
                 || cmd.char_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && emit_char) begin
      out_char <= mapped;
      out_cv   <= 1'b1;
      out_last <= s_tlast;
      out_ovf  <= ovf;
    end else if (cmd.accept && emit_mark) begin
      out_char <= '0;
      out_cv   <= 1'b0;
      out_last <= 1'b1;
      out_ovf  <= ovf || set_ovf;
    end else if (cmd.flush_load) begin
      out_char <= rd_data;
      out_cv   <= 1'b1;
      out_last <= 1'b0;
      out_ovf  <= ovf;
    end else if (cmd.char_load) begin
      out_char <= hold_char;
      out_cv   <= 1'b1;
      out_last <= hold_last;
      out_ovf  <= ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tuser  = {out_ovf, out_cv};
  assign m_tlast  = out_last;

`ifndef ASSERT_OFF
  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_load |-> (CW'(idx) < count))
    else $error("drain index beyond pending count");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.char_load && hold_last) |=> (count == '0 && !ovf && !seen && !prev_space))
    else $error("string state not cleared at end of string");

  a_buffer_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && buf_wr && !s_tlast && !cfg_we) |=> (count == $past(count) + CW'(1)))
    else $error("pending count did not advance on buffered byte");

  a_overflow_sticks: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && set_ovf && !s_tlast && !cfg_we) |=> ovf)
    else $error("overflow not recorded");
`endif

endmodule

`default_nettype wire

// ===== rtl/text_whitespace_normalizer.sv =====
// a byte that yields a result goes into the output register on its beat, or into
// hold_char first when it follows buffered whitespace; throughput: one byte per cycle
// while no buffered whitespace is pending and the output is free; the input stalls
// while the buffer drains through its single read port, one byte per free cycle
// reset: synchronous, clears control and string state, sentence_mode returns to 1;
// the pending buffer is not cleared, entries are read only after being written
`timescale 1ns / 1ps
`default_nettype none

module text_whitespace_normalizer
  import tnw_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  // configuration
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [APB_ADDR_W-1:0]  paddr,
  input  wire  [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // input stream
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire  [CHAR_W-1:0]      s_tdata,   // char_in
  input  wire                    s_tlast,   // last_in
  // output stream
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [CHAR_W-1:0]      m_tdata,   // char_out
  output logic [1:0]             m_tuser,   // [0] char_valid, [1] overflow
  output logic                   m_tlast    // last_out
);

  tnw_cmd_t    cmd;
  tnw_status_t status;
  logic        cfg_we;
  logic        sentence_mode;
  logic        sel_mode;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[2] == REG_SENTENCE_MODE);
  assign cfg_we   = psel && penable && pwrite && pready && sel_mode;
  assign prdata   = sel_mode ? {{(APB_DATA_W-1){1'b0}}, sentence_mode} : '0;

  tnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tnw_datapath #(
    .DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_mode      (pwdata[0]),
    .sentence_mode (sentence_mode),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .cmd           (cmd),
    .status        (status),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/tb_text_whitespace_normalizer.sv =====
// self-checking testbench for text_whitespace_normalizer
// streams byte strings in both trim modes and checks every output beat against
// an in-bench normalizer model; depends on tnw_pkg and the rtl top only
`timescale 1ns / 1ps

module tb_text_whitespace_normalizer;
  import tnw_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          LIMIT_CYCLES  = 500000;
  localparam logic [APB_ADDR_W-1:0] ADDR_MODE  = APB_ADDR_W'({REG_SENTENCE_MODE, 2'b00});
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = ADDR_MODE + APB_ADDR_W'(4);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              last;
    logic              ovf;
  } norm_result_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CHAR_W-1:0]     s_tdata  = '0;   // char_in
  logic                  s_tlast  = 1'b0; // last_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [CHAR_W-1:0]     m_tdata;         // char_out
  logic [1:0]            m_tuser;         // [0] char_valid, [1] overflow
  logic                  m_tlast;         // last_out

  text_whitespace_normalizer #(.PENDING_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // normalizer model state
  logic              text_mode;
  logic              seen_text;
  logic              prev_space;
  logic [CHAR_W-1:0] pend_ws [DEPTH];
  int                pend_cnt;
  logic              ws_overflow;

  text_beat_t   bytes_to_send [$];
  norm_result_t expected_chars [$];

  bit no_gaps   = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int send_wait = 0;
  int recv_wait = 0;

  int fail_count    = 0;
  int bytes_queued  = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int strings_seen  = 0;
  int bare_markers  = 0;
  int ovf_results   = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;

  function automatic bit is_blank(logic [CHAR_W-1:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  function automatic void restart_string();
    seen_text   = 1'b0;
    prev_space  = 1'b0;
    pend_cnt    = 0;
    ws_overflow = 1'b0;
  endfunction

  function automatic void expect_char(logic [CHAR_W-1:0] c, logic valid, logic last);
    norm_result_t r;
    r.ch    = valid ? c : '0;
    r.valid = valid;
    r.last  = last;
    r.ovf   = ws_overflow;
    expected_chars.push_back(r);
  endfunction

  // maps, collapses and trims one accepted byte, queueing the beats it releases
  function automatic void normalize_byte(logic [CHAR_W-1:0] raw, logic last_flag);
    logic [CHAR_W-1:0] c;
    int                produced;
    c        = raw;
    produced = expected_chars.size();
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) c = c + CASE_OFFSET;
    if (c[HIGH_BIT]) c = CHR_SPACE;
    if (!text_mode) begin
      if (!(c == CHR_SPACE && prev_space)) begin
        prev_space = (c == CHR_SPACE);
        expect_char(c, 1'b1, last_flag);
      end
    end else if (!is_blank(c)) begin
      seen_text = 1'b1;
      for (int i = 0; i < pend_cnt; i++) expect_char(pend_ws[i], 1'b1, 1'b0);
      pend_cnt   = 0;
      prev_space = 1'b0;
      expect_char(c, 1'b1, last_flag);
    end else if (seen_text) begin
      if (c == CHR_SPACE && prev_space) begin
        // dropped before reaching the buffer
      end else if (pend_cnt < DEPTH) begin
        pend_ws[pend_cnt] = c;
        pend_cnt++;
        prev_space = (c == CHR_SPACE);
      end else begin
        ws_overflow = 1'b1;
      end
    end
    if (last_flag) begin
      if (expected_chars.size() == produced) expect_char('0, 1'b0, 1'b1);
      restart_string();
    end
  endfunction

  // sender: one beat per queued byte, random gap after each accepted beat unless no_gaps is set
  always @(posedge clk) begin : sender
    text_beat_t beat;
    if (rst) begin
      s_tvalid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        normalize_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (s_tvalid && !s_tready) begin
        // keep offering the same beat
      end else if (send_wait != 0) begin
        s_tvalid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (bytes_to_send.size() != 0) begin
        beat = bytes_to_send.pop_front();
        s_tvalid  <= 1'b1;
        s_tdata   <= beat.ch;
        s_tlast   <= beat.last;
        send_wait <= no_gaps ? 0 : $urandom_range(0, 15);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: checks each output beat against the oldest expectation
  always @(posedge clk) begin : receiver
    norm_result_t got;
    norm_result_t want;
    int           w;
    if (rst) begin
      m_tready  <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (m_tvalid && m_tready) begin
        got.ch    = m_tdata;
        got.valid = m_tuser[0];
        got.last  = m_tlast;
        got.ovf   = m_tuser[1];
        results_seen++;
        if (got.last) strings_seen++;
        if (!got.valid) bare_markers++;
        if (got.ovf) ovf_results++;
        if (expected_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat %0d: char %02h valid %0b last %0b ovf %0b",
                     results_seen, got.ch, got.valid, got.last, got.ovf);
        end else begin
          want = expected_chars.pop_front();
          if (got.ch !== want.ch || got.valid !== want.valid ||
              got.last !== want.last || got.ovf !== want.ovf) begin
            fail_count++;
            if (fail_count <= 10)
              $display("beat %0d: expected char %02h valid %0b last %0b ovf %0b, got %02h %0b %0b %0b",
                       results_seen, want.ch, want.valid, want.last, want.ovf,
                       got.ch, got.valid, got.last, got.ovf);
          end
        end
        w = no_gaps ? 0 : $urandom_range(0, 15);
      end
      if (hold_left != 0) begin
        m_tready  <= 1'b0;
        recv_wait <= w;
      end else if (w != 0) begin
        m_tready  <= 1'b0;
        recv_wait <= w - 1;
      end else begin
        m_tready  <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_byte(input logic [CHAR_W-1:0] c, input logic last);
    text_beat_t b;
    b.ch   = c;
    b.last = last;
    bytes_to_send.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [CHAR_W-1:0] rand_text_char();
    case ($urandom_range(0, 5))
      0:       return CHAR_W'($urandom_range(65, 90));
      1:       return CHAR_W'($urandom_range(97, 122));
      2:       return CHAR_W'($urandom_range(33, 64));
      3:       return CHAR_W'($urandom_range(91, 127));
      4:       return CHAR_W'($urandom_range(128, 255));
      default: return CHAR_W'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_blank();
    case ($urandom_range(0, 3))
      0, 1:    return CHR_SPACE;
      2:       return CHAR_W'($urandom_range(9, 13));
      default: return CHAR_W'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic queue_blanks(input int n);
    repeat (n) push_byte(rand_blank(), 1'b0);
  endtask

  // words separated by blank runs; some runs long enough to overflow the buffer
  task automatic queue_string(input int words, input bit trailing);
    if ($urandom_range(0, 2) == 0) queue_blanks($urandom_range(1, 3));
    for (int w = 0; w < words; w++) begin
      if (w != 0)
        queue_blanks($urandom_range(0, 5) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 3));
      repeat ($urandom_range(1, 6)) push_byte(rand_text_char(), 1'b0);
    end
    if (trailing || words == 0) queue_blanks($urandom_range(1, 4));
    bytes_to_send[bytes_to_send.size() - 1].last = 1'b1;
  endtask

  task automatic run_random(input int target);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_string($urandom_range(1, 5), $urandom_range(0, 1));
      end else if (pick == 7) begin
        queue_string(0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) push_byte(CHAR_W'($urandom_range(1, 255)), 1'b0);
        bytes_to_send[bytes_to_send.size() - 1].last = 1'b1;
      end
    end
  endtask

  // leaves a string open, with whitespace buffered in sentence mode, ahead of a register write
  task automatic queue_open_string();
    push_byte(rand_text_char() | 8'h61, 1'b0);
    push_byte(CHR_SPACE, 1'b0);
    push_byte(CHR_TAB, 1'b0);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || s_tvalid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [APB_DATA_W-1:0] data,
                          output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write, update the model, then read the mode register back
  task automatic set_register(input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] rdata;
    apb_xfer(1'b1, addr, data, rdata);
    if (addr == ADDR_MODE) begin
      text_mode = data[0];
      restart_string();
    end
    reg_writes++;
    apb_xfer(1'b0, ADDR_MODE, '0, rdata);
    if (rdata !== APB_DATA_W'(text_mode)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mode read back %08h, expected %0b", rdata, text_mode);
    end
  endtask

  initial begin
    static logic [CHAR_W-1:0] opening [16] = '{
      8'h20, 8'h0a, 8'h41, 8'h20, 8'h20, 8'h0d, 8'h80, 8'h5a,
      8'h01, 8'h08, 8'h0e, 8'h40, 8'h5b, 8'h7f, 8'h09, 8'hff
    };
    text_mode = SENTENCE_MODE_RESET;
    restart_string();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    // leading trim, case map, collapse, high-bit bytes, ends on whitespace
    foreach (opening[i]) push_byte(opening[i], i == 15);
    // 17 non-collapsing blanks after text overflow the buffer, then a full flush
    push_byte(8'h61, 1'b0);
    for (int i = 0; i < 17; i++) push_byte(i[0] ? CHR_SPACE : CHR_TAB, 1'b0);
    push_byte(8'h7a, 1'b1);
    wait_idle();

    @(negedge clk);
    run_random(10);
    queue_open_string();
    wait_idle();
    // write outside the register map must not disturb the open string
    set_register(ADDR_SPARE, '1);

    @(negedge clk);
    no_gaps = 1'b1;
    run_random(6);
    queue_open_string();
    wait_idle();
    set_register(ADDR_MODE, 32'hffff_fffe);

    @(negedge clk);
    hold_go = 1'b1;
    run_random(6);
    queue_open_string();
    wait_idle();
    set_register(ADDR_MODE, 32'hffff_ffff);

    @(negedge clk);
    no_gaps = 1'b0;
    run_random(6);
    wait_idle();
    set_register(ADDR_MODE, 32'h0000_0000);

    @(negedge clk);
    run_random(4);
    wait_idle();
    set_register(ADDR_MODE, 32'h0000_0001);

    @(negedge clk);
    run_random(2);
    wait_idle();

    $display("run covered %0d bytes and %0d output beats over %0d strings in both modes",
             bytes_sent, results_seen, strings_seen);
    $display("%0d bare end markers, %0d overflow beats, %0d register writes, %0d-cycle stall",
             bare_markers, ovf_results, reg_writes, HOLD_CYCLES);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
